FILE: rtl/core/complex_elementwise_alu_macros.svh
// ----------------------------------------------------------------------------
// complex_elementwise_alu_macros
// Assertion macros shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ELEMENTWISE_ALU_MACROS_SVH
`define COMPLEX_ELEMENTWISE_ALU_MACROS_SVH

// The condition implies the expression in the same cycle.
`define CAE_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// The condition implies the expression in the next cycle.
`define CAE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/core/cae_pkg.sv
// ----------------------------------------------------------------------------
// cae_pkg
// Types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cae_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUO_BITS  = 32;
  localparam int NUM_CELLS = QUO_BITS;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_SQR  = 3'd4,
    OP_NEG  = 3'd5,
    OP_CONJ = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] left_re;
    logic [31:0] left_im;
    logic [31:0] right_re;
    logic [31:0] right_im;
  } cae_in_t;

  // Word handed along the divider chain. Non-divide results ride along in
  // res_re, res_im and sat.
  typedef struct packed {
    logic        is_div;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        sat;
    logic        dz;
    logic [63:0] den;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [QUO_BITS-1:0] dvd_re;
    logic [QUO_BITS-1:0] dvd_im;
    logic [QUO_BITS-1:0] quo_re;
    logic [QUO_BITS-1:0] quo_im;
  } cae_word_t;

endpackage

FILE: rtl/core/cae_if.sv
// ----------------------------------------------------------------------------
// cae_if
// Valid/ready channels of the complex arithmetic unit.
// ----------------------------------------------------------------------------
interface cae_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic signed [31:0] left_re;
  logic signed [31:0] left_im;
  logic signed [31:0] right_re;
  logic signed [31:0] right_im;

  modport source(output valid, func, left_re, left_im, right_re, right_im,
                 input ready);
  modport sink(input valid, func, left_re, left_im, right_re, right_im,
               output ready);
endinterface

interface cae_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic        saturated;
  logic        div_by_zero;

  modport source(output valid, res_re, res_im, saturated, div_by_zero,
                 input ready);
  modport sink(input valid, res_re, res_im, saturated, div_by_zero,
               output ready);
endinterface

FILE: rtl/core/cae_front.sv
// ----------------------------------------------------------------------------
// cae_front
// Three-stage front end: products and short ops, sums with rounding, divider setup.
// ----------------------------------------------------------------------------
module cae_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cae_pkg::cae_in_t    in_word,
  output logic                o_valid,
  input  logic                o_ready,
  output cae_pkg::cae_word_t  o_word
);

  localparam int F = cae_pkg::FRAC_BITS;
  localparam logic signed [65:0] RND = 66'((64'd1 << F) >> 1);

  typedef struct packed {
    cae_pkg::op_t       op;
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic signed [63:0] pc;
    logic signed [63:0] pd;
    logic signed [63:0] pe;
    logic signed [63:0] pf;
    logic [31:0]        re;
    logic [31:0]        im;
    logic               sat;
  } s1_t;

  typedef struct packed {
    logic        is_div;
    logic [31:0] re;
    logic [31:0] im;
    logic        sat;
    logic        dz;
    logic [63:0] den;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
  } s2_t;

  // Returns {clipped, value}.
  function automatic logic [32:0] sat33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = {1'b1, (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] rnd_sat(input logic signed [65:0] v);
    logic signed [65:0] t;
    logic signed [65:0] s;
    logic [32:0]        r;
    t = v + RND;
    s = t >>> F;
    if ((&s[65:31]) || !(|s[65:31])) begin
      r = {1'b0, s[31:0]};
    end else begin
      r = {1'b1, (s[65] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end
    return r;
  endfunction

  function automatic logic signed [65:0] ext66(input logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  logic s1_v_r, s2_v_r, o_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  cae_pkg::cae_word_t o_r, o_nxt;
  logic s1_ready, s2_ready, o_ready_int;

  assign o_ready_int = !o_v_r || o_ready;
  assign s2_ready    = !s2_v_r || o_ready_int;
  assign s1_ready    = !s1_v_r || s2_ready;
  assign in_ready    = s1_ready;
  assign o_valid     = o_v_r;
  assign o_word      = o_r;

  // Stage 1: four cross products, the divisor squares, and the short ops.
  logic signed [31:0] lr, li, rr, ri, a0, a1;
  logic signed [32:0] lr33, li33, rr33, ri33;
  logic [32:0]        t_re, t_im;

  always_comb begin
    lr = in_word.left_re;
    li = in_word.left_im;
    rr = in_word.right_re;
    ri = in_word.right_im;
    lr33 = {lr[31], lr};
    li33 = {li[31], li};
    rr33 = {rr[31], rr};
    ri33 = {ri[31], ri};
    s1_nxt.op = cae_pkg::op_t'(in_word.func);
    a0 = (s1_nxt.op == cae_pkg::OP_SQR) ? rr : lr;
    a1 = (s1_nxt.op == cae_pkg::OP_SQR) ? ri : li;
    s1_nxt.pa = a0 * rr;
    s1_nxt.pb = a1 * ri;
    s1_nxt.pc = a0 * ri;
    s1_nxt.pd = a1 * rr;
    s1_nxt.pe = rr * rr;
    s1_nxt.pf = ri * ri;
    t_re = '0;
    t_im = '0;
    unique case (s1_nxt.op)
      cae_pkg::OP_ADD: begin
        t_re = sat33(lr33 + rr33);
        t_im = sat33(li33 + ri33);
      end
      cae_pkg::OP_SUB: begin
        t_re = sat33(lr33 - rr33);
        t_im = sat33(li33 - ri33);
      end
      cae_pkg::OP_NEG: begin
        t_re = sat33(33'sd0 - rr33);
        t_im = sat33(33'sd0 - ri33);
      end
      cae_pkg::OP_CONJ: begin
        t_re = {1'b0, rr};
        t_im = sat33(33'sd0 - ri33);
      end
      default: begin
        t_re = '0;
        t_im = '0;
      end
    endcase
    s1_nxt.re  = t_re[31:0];
    s1_nxt.im  = t_im[31:0];
    s1_nxt.sat = t_re[32] | t_im[32];
  end

  // Stage 2: exact sums, rounding of products, divisor and magnitudes.
  logic signed [65:0] sum_re, sum_im, nre, nim, nre_neg, nim_neg;
  logic [32:0]        m_re, m_im;

  always_comb begin
    sum_re  = ext66(s1_r.pa) - ext66(s1_r.pb);
    sum_im  = ext66(s1_r.pc) + ext66(s1_r.pd);
    nre     = ext66(s1_r.pa) + ext66(s1_r.pb);
    nim     = ext66(s1_r.pd) - ext66(s1_r.pc);
    nre_neg = -nre;
    nim_neg = -nim;
    m_re    = rnd_sat(sum_re);
    m_im    = rnd_sat(sum_im);
    s2_nxt.is_div = (s1_r.op == cae_pkg::OP_DIV);
    s2_nxt.den    = $unsigned(s1_r.pe) + $unsigned(s1_r.pf);
    s2_nxt.dz     = s2_nxt.is_div && (s2_nxt.den == 64'd0);
    s2_nxt.neg_re = nre[65];
    s2_nxt.neg_im = nim[65];
    s2_nxt.mag_re = nre[65] ? nre_neg[63:0] : nre[63:0];
    s2_nxt.mag_im = nim[65] ? nim_neg[63:0] : nim[63:0];
    if ((s1_r.op == cae_pkg::OP_MUL) || (s1_r.op == cae_pkg::OP_SQR)) begin
      s2_nxt.re  = m_re[31:0];
      s2_nxt.im  = m_im[31:0];
      s2_nxt.sat = m_re[32] | m_im[32];
    end else begin
      s2_nxt.re  = s1_r.re;
      s2_nxt.im  = s1_r.im;
      s2_nxt.sat = s1_r.sat;
    end
  end

  // Stage 3: scale the numerators, catch quotients that cannot fit and
  // seed the partial remainders with the upper dividend bits.
  logic [95:0] sc_re, sc_im, den_hi;

  always_comb begin
    sc_re  = {32'd0, s2_r.mag_re} << F;
    sc_im  = {32'd0, s2_r.mag_im} << F;
    den_hi = {s2_r.den, 32'd0};
    o_nxt.is_div = s2_r.is_div;
    o_nxt.res_re = s2_r.re;
    o_nxt.res_im = s2_r.im;
    o_nxt.sat    = s2_r.sat;
    o_nxt.dz     = s2_r.dz;
    o_nxt.den    = s2_r.den;
    o_nxt.neg_re = s2_r.neg_re;
    o_nxt.neg_im = s2_r.neg_im;
    o_nxt.ovf_re = (sc_re >= den_hi);
    o_nxt.ovf_im = (sc_im >= den_hi);
    o_nxt.rem_re = sc_re[95:32];
    o_nxt.rem_im = sc_im[95:32];
    o_nxt.dvd_re = sc_re[31:0];
    o_nxt.dvd_im = sc_im[31:0];
    o_nxt.quo_re = '0;
    o_nxt.quo_im = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (o_ready_int) o_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1_r <= s1_nxt;
    if (s2_ready && s1_v_r) s2_r <= s2_nxt;
    if (o_ready_int && s2_v_r) o_r <= o_nxt;
  end

endmodule

FILE: rtl/core/cae_cell.sv
// ----------------------------------------------------------------------------
// cae_cell
// One restoring-division cell: retires one quotient bit of each part.
// ----------------------------------------------------------------------------
module cae_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_ready,
  input  cae_pkg::cae_word_t  i_word,
  output logic                o_valid,
  input  logic                o_ready,
  output cae_pkg::cae_word_t  o_word
);

  localparam int QB = cae_pkg::QUO_BITS;

  logic               v_r;
  cae_pkg::cae_word_t w_r, w_nxt;
  logic [64:0]        sh_re, sh_im, dif_re, dif_im, den65;
  logic               ge_re, ge_im;

  assign i_ready = !v_r || o_ready;
  assign o_valid = v_r;
  assign o_word  = w_r;

  always_comb begin
    den65  = {1'b0, i_word.den};
    sh_re  = {i_word.rem_re, i_word.dvd_re[QB-1]};
    sh_im  = {i_word.rem_im, i_word.dvd_im[QB-1]};
    dif_re = sh_re - den65;
    dif_im = sh_im - den65;
    ge_re  = (sh_re >= den65);
    ge_im  = (sh_im >= den65);
    w_nxt  = i_word;
    w_nxt.rem_re = ge_re ? dif_re[63:0] : sh_re[63:0];
    w_nxt.rem_im = ge_im ? dif_im[63:0] : sh_im[63:0];
    w_nxt.dvd_re = {i_word.dvd_re[QB-2:0], 1'b0};
    w_nxt.dvd_im = {i_word.dvd_im[QB-2:0], 1'b0};
    w_nxt.quo_re = {i_word.quo_re[QB-2:0], ge_re};
    w_nxt.quo_im = {i_word.quo_im[QB-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (i_ready) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) w_r <= w_nxt;
  end

endmodule

FILE: rtl/core/cae_post.sv
// ----------------------------------------------------------------------------
// cae_post
// Quotient rounding, sign, saturation and the output register.
// ----------------------------------------------------------------------------
module cae_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_ready,
  input  cae_pkg::cae_word_t  i_word,
  output logic                o_valid,
  input  logic                o_ready,
  output logic [31:0]         o_re,
  output logic [31:0]         o_im,
  output logic                o_sat,
  output logic                o_dz
);

  localparam int QB = cae_pkg::QUO_BITS;

  // Returns {clipped, value}.
  function automatic logic [32:0] fin(input logic [QB-1:0] quo,
                                      input logic [63:0] rem,
                                      input logic [63:0] den,
                                      input logic neg, input logic ovf);
    logic [32:0] q1;
    logic [32:0] lim;
    logic [32:0] nq;
    logic        up;
    logic [32:0] r;
    up  = ({rem, 1'b0} >= {1'b0, den});
    q1  = {1'b0, quo} + {32'd0, up};
    lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    nq  = -q1;
    if (ovf || (q1 > lim)) begin
      r = {1'b1, (neg ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end else begin
      r = {1'b0, (neg ? nq[31:0] : q1[31:0])};
    end
    return r;
  endfunction

  logic        v_r;
  logic [31:0] re_r, im_r, re_nxt, im_nxt;
  logic        sat_r, dz_r, sat_nxt, dz_nxt;
  logic [32:0] f_re, f_im;

  assign i_ready = !v_r || o_ready;
  assign o_valid = v_r;
  assign o_re    = re_r;
  assign o_im    = im_r;
  assign o_sat   = sat_r;
  assign o_dz    = dz_r;

  always_comb begin
    f_re = fin(i_word.quo_re, i_word.rem_re, i_word.den, i_word.neg_re, i_word.ovf_re);
    f_im = fin(i_word.quo_im, i_word.rem_im, i_word.den, i_word.neg_im, i_word.ovf_im);
    if (!i_word.is_div) begin
      re_nxt  = i_word.res_re;
      im_nxt  = i_word.res_im;
      sat_nxt = i_word.sat;
      dz_nxt  = 1'b0;
    end else if (i_word.dz) begin
      re_nxt  = '0;
      im_nxt  = '0;
      sat_nxt = 1'b0;
      dz_nxt  = 1'b1;
    end else begin
      re_nxt  = f_re[31:0];
      im_nxt  = f_im[31:0];
      sat_nxt = f_re[32] | f_im[32];
      dz_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (i_ready) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      sat_r <= sat_nxt;
      dz_r  <= dz_nxt;
    end
  end

endmodule

FILE: rtl/core/complex_elementwise_alu.sv
// ----------------------------------------------------------------------------
// complex_elementwise_alu
// Element-wise complex add, subtract, multiply, divide, square, negate and
// conjugate on Q16.16 components with saturation. The unit takes one word
// per clock while the output is not stalled and returns one result word per
// input word, in order: three front stages form the products, rounded sums
// and divider setup, a chain of 32 division cells retires one quotient bit
// each, and a final stage rounds, saturates and holds the result. Every
// operation travels the same chain, so throughput is one word per cycle for
// any mix of codes while the output is not stalled. Each stage takes a word
// whenever it is empty or its successor takes its own word in the same
// cycle, so the ready path runs combinationally back through all stages and
// bubbles in the chain are filled while the output waits.
// ----------------------------------------------------------------------------
`include "complex_elementwise_alu_macros.svh"

module complex_elementwise_alu (
  input  logic      clk,
  input  logic      rst_n,
  cae_in_if.sink    in_if,
  cae_out_if.source out_if
);

  localparam int N = cae_pkg::NUM_CELLS;

  cae_pkg::cae_in_t   in_word;
  cae_pkg::cae_word_t ch_w [N+1];
  logic               ch_v [N+1];
  logic               ch_r [N+1];
  logic [31:0]        res_re, res_im;

  assign in_word.func     = in_if.func;
  assign in_word.left_re  = in_if.left_re;
  assign in_word.left_im  = in_if.left_im;
  assign in_word.right_re = in_if.right_re;
  assign in_word.right_im = in_if.right_im;

  cae_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_word  (in_word),
    .o_valid  (ch_v[0]),
    .o_ready  (ch_r[0]),
    .o_word   (ch_w[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    cae_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (ch_v[g]),
      .i_ready (ch_r[g]),
      .i_word  (ch_w[g]),
      .o_valid (ch_v[g+1]),
      .o_ready (ch_r[g+1]),
      .o_word  (ch_w[g+1])
    );
  end

  cae_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (ch_v[N]),
    .i_ready (ch_r[N]),
    .i_word  (ch_w[N]),
    .o_valid (out_if.valid),
    .o_ready (out_if.ready),
    .o_re    (res_re),
    .o_im    (res_im),
    .o_sat   (out_if.saturated),
    .o_dz    (out_if.div_by_zero)
  );

  assign out_if.res_re = res_re;
  assign out_if.res_im = res_im;

  `CAE_ASSERT_SAME(a_dz_zero, clk, rst_n, out_if.valid && out_if.div_by_zero, (res_re == 32'd0) && (res_im == 32'd0) && !out_if.saturated, "divide by zero word is not a clean zero")
  `CAE_ASSERT_SAME(a_empty_ready, clk, rst_n, !out_if.valid, in_if.ready, "input stalled while the output register is empty")
  `CAE_ASSERT_NEXT(a_last_moves, clk, rst_n, ch_v[N] && !out_if.valid, out_if.valid, "last cell word did not reach the empty output register")

endmodule
